[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and constants of the bounded deque with search
// ----------------------------------------------------------------------------
package bdq_pkg;

   // default number of ring entries
   localparam int DEPTH_DEF = 16;

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int VAL_W    = 32;
   localparam int FOUND_W  = 5;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // position reported when nothing matches, or for any other operation
   localparam logic [FOUND_W-1:0] FOUND_NONE = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_BACK   = 2'd2,
      OP_FIND       = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // control strobes from the sequencer to the ring store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

[rtl/bdq_if.sv]
// ----------------------------------------------------------------------------
// bdq request and response channels
// valid/ready channels carrying one operation and one result
// ----------------------------------------------------------------------------
interface bdq_req_if import bdq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic signed [VAL_W-1:0] item_value;

   modport source (output valid, output op, output item_value, input ready);
   modport sink   (input valid, input op, input item_value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VAL_W-1:0]   popped_value;
   logic signed [FOUND_W-1:0] found_position;
   logic [STATUS_W-1:0]       status;
   logic [FILL_W-1:0]         fill_count;

   modport source (output valid, output popped_value, output found_position,
                   output status, output fill_count, input ready);
   modport sink   (input valid, input popped_value, input found_position,
                   input status, input fill_count, output ready);
endinterface

[rtl/bdq_mem.sv]
// ----------------------------------------------------------------------------
// bdq_mem
// ring element store, one write and one registered read port
// ----------------------------------------------------------------------------
module bdq_mem import bdq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  mem_ctl_type      ctl,
   input  logic [PTR_W-1:0] wr_addr,
   input  logic [VAL_W-1:0] wr_data,
   input  logic [PTR_W-1:0] rd_addr,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0] store_mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bdq_addr_unit.sv]
// ----------------------------------------------------------------------------
// bdq_addr_unit
// shared ring slot adder with wrap, and the search key comparator
// ----------------------------------------------------------------------------
module bdq_addr_unit import bdq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic [PTR_W-1:0] base,
   input  logic [PTR_W-1:0] offset,
   input  logic [VAL_W-1:0] key,
   input  logic [VAL_W-1:0] data,
   output logic [PTR_W-1:0] slot,
   output logic             hit
);

   localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W+1)'(DEPTH);

   logic [PTR_W:0] sum;
   logic [PTR_W:0] sum_wrapped;

   // both operands stay below the depth, so one subtract wraps the sum
   assign sum         = {1'b0, base} + {1'b0, offset};
   assign sum_wrapped = sum - DEPTH_EXT;
   assign slot        = (sum >= DEPTH_EXT) ? sum_wrapped[PTR_W-1:0] : sum[PTR_W-1:0];
   assign hit         = (key == data);

endmodule

[rtl/bounded_deque_with_search.sv]
// a push, a rejected push or pop, and a find on an empty store answer in the cycle after
// the request transfer; a pop answers via S_POP, where the registered store read lands
// a find compares k elements in S_FIND (k at most DEPTH), with one store
// read and one compare per cycle through the shared slot adder and comparator
// one operation at a time: the next request transfer is taken once the response is taken
// reset (synchronous, active high) empties the deque; store contents are left undefined
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded double-ended queue of signed values in a ring store, with a linear
// search that reports the position of the first match from the front
// ----------------------------------------------------------------------------
module bounded_deque_with_search import bdq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bdq_req_if.sink    req_chan,
   bdq_rsp_if.source  rsp_chan
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,   // waiting for a request transfer
      S_POP  = 4'b0010,   // store read for pop in flight
      S_FIND = 4'b0100,   // one element compared per cycle
      S_RESP = 4'b1000    // result held until its transfer
   } state_type;

   state_type state_ff, state_in;

   // deque pointers
   logic [PTR_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // search bookkeeping
   logic [VAL_W-1:0] key_ff, key_in;
   logic [PTR_W-1:0] cmp_idx_ff, cmp_idx_in;   // index of element in rd_data
   logic [PTR_W-1:0] ahead_ff, ahead_in;       // slot of the next read

   // result registers
   logic [VAL_W-1:0]   popped_ff, popped_in;
   logic [FOUND_W-1:0] found_ff, found_in;
   status_type         status_ff, status_in;

   // shared unit and store hookup
   logic [PTR_W-1:0] unit_base;
   logic [PTR_W-1:0] unit_offset;
   logic [PTR_W-1:0] unit_slot;
   logic             unit_hit;
   mem_ctl_type      mem_ctl;
   logic [PTR_W-1:0] mem_rd_addr;
   logic [VAL_W-1:0] mem_rd_data;

   logic   req_xfer;
   logic   is_full;
   logic   is_empty;
   logic   last_cmp;
   op_type req_op;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_op   = op_type'(req_chan.op);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   // compared element is the back one
   assign last_cmp = (CNT_W'(cmp_idx_ff) == count_ff - CNT_W'(1));

   // slot adder operands: in idle the base is the front, while searching it is
   // the read-ahead slot stepped by one
   always_comb begin
      unit_base   = front_ff;
      unit_offset = PTR_W'(1);
      if (state_ff == S_FIND) begin
         unit_base   = ahead_ff;
         unit_offset = PTR_W'(1);
      end else begin
         unique case (req_op)
            OP_PUSH_BACK:  unit_offset = count_ff[PTR_W-1:0];
            OP_PUSH_FRONT: unit_offset = PTR_W'(DEPTH - 1);
            OP_POP_BACK:   unit_offset = PTR_W'(count_ff - CNT_W'(1));
            OP_FIND:       unit_offset = PTR_W'(1);
         endcase
      end
   end

   bdq_addr_unit #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_addr_unit (
      .base   (unit_base),
      .offset (unit_offset),
      .key    (key_ff),
      .data   (mem_rd_data),
      .slot   (unit_slot),
      .hit    (unit_hit)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      cmp_idx_in  = cmp_idx_ff;
      ahead_in    = ahead_ff;
      popped_in   = popped_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      mem_ctl     = '0;
      mem_rd_addr = unit_slot;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               // defaults of a result that is not a pop or a match
               popped_in = '0;
               found_in  = FOUND_NONE;
               status_in = ST_OK;
               state_in  = S_RESP;
               unique case (req_op)
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        // front steps back by one with wrap, new value lands there
                        mem_ctl.wr_en = 1'b1;
                        front_in      = unit_slot;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        count_in      = count_ff - CNT_W'(1);
                        state_in      = S_POP;
                     end
                  end
                  OP_FIND: begin
                     key_in = req_chan.item_value;
                     if (!is_empty) begin
                        // first read at the front, next one already queued up
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = front_ff;
                        cmp_idx_in    = '0;
                        ahead_in      = unit_slot;
                        state_in      = S_FIND;
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            popped_in = mem_rd_data;
            state_in  = S_RESP;
         end
         S_FIND: begin
            // read one element ahead while comparing the current one
            mem_ctl.rd_en = 1'b1;
            mem_rd_addr   = ahead_ff;
            ahead_in      = unit_slot;
            if (unit_hit) begin
               found_in = FOUND_W'(cmp_idx_ff);
               state_in = S_RESP;
            end else if (last_cmp) begin
               state_in = S_RESP;
            end else begin
               cmp_idx_in = PTR_W'(cmp_idx_ff + 1'b1);
            end
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   bdq_mem #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (unit_slot),
      .wr_data (req_chan.item_value),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // search and result payload, no reset needed
   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      cmp_idx_ff <= cmp_idx_in;
      ahead_ff   <= ahead_in;
      popped_ff  <= popped_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
   end

   // channel outputs
   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = (state_ff == S_RESP);
   assign rsp_chan.popped_value   = popped_ff;
   assign rsp_chan.found_position = found_ff;
   assign rsp_chan.status         = status_ff;
   // fill count after the operation, taken modulo the field width
   assign rsp_chan.fill_count     = FILL_W'(count_ff);

endmodule

[rtl/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks of the bounded deque, bound to the top level
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [VAL_W-1:0]    rsp_popped_value,
   input logic [FOUND_W-1:0]  rsp_found_position,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [FILL_W-1:0]   rsp_fill_count
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_value)
         && $stable(rsp_found_position) && $stable(rsp_status)
         && $stable(rsp_fill_count))
      else $error("response changed while stalled");

   // one operation in flight
   a_single_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request ready while a response is pending");

   // dropped push leaves a full store and no pop or match
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_fill_count == FILL_W'(DEPTH)
         && rsp_popped_value == '0 && rsp_found_position == FOUND_NONE)
      else $error("bad result of push on full store");

   // pop on empty reports an empty store and a zero value
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_fill_count == '0
         && rsp_popped_value == '0 && rsp_found_position == FOUND_NONE)
      else $error("bad result of pop on empty store");

endmodule

bind bounded_deque_with_search bdq_checker #(
   .DEPTH (DEPTH)
) u_bdq_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_popped_value   (rsp_chan.popped_value),
   .rsp_found_position (rsp_chan.found_position),
   .rsp_status         (rsp_chan.status),
   .rsp_fill_count     (rsp_chan.fill_count)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounded deque with search: a directed pass over
// the corner cases, then random bursts of push, pop and find operations with a
// stalling receiver, all checked against an in-bench deque predictor
// ----------------------------------------------------------------------------
module tb;
   import bdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = DEPTH_DEF;
   localparam int RANDOM_OPS    = 800;
   localparam int IDLE_LIMIT    = 2000;   // cycles with no transfer on either channel
   localparam int HOLDOFF_AFTER = 300;    // request count that triggers the long stall
   localparam int HOLDOFF_LEN   = 250;
   localparam int DRAIN_CYCLES  = 40;     // settle time after the last awaited response

   // one expected response
   typedef struct packed {
      logic signed [VAL_W-1:0]   popped;
      logic signed [FOUND_W-1:0] found;
      status_type                status;
      logic [FILL_W-1:0]         fill;
   } deque_result_type;

   // deque predictor plus the queue of responses it still awaits
   class deque_scoreboard;
      logic [VAL_W-1:0] held_values [DEPTH];
      int               head;
      int               held;
      deque_result_type awaited_results [$];
      int               errors;
      int               full_drops;
      int               empty_pops;
      int               find_hits;
      int               find_misses;
      int               peak_fill;

      function new();
         head = 0;
         held = 0;
         errors = 0;
         full_drops = 0;
         empty_pops = 0;
         find_hits = 0;
         find_misses = 0;
         peak_fill = 0;
      endfunction

      // apply one accepted operation and queue the response it must produce
      function void apply_operation(op_type op, logic [VAL_W-1:0] value);
         deque_result_type r;
         r.popped = '0;
         r.found  = FOUND_NONE;
         r.status = ST_OK;
         case (op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
               if (held == DEPTH) begin
                  r.status = ST_FULL;
                  full_drops++;
               end else if (op == OP_PUSH_BACK) begin
                  held_values[(head + held) % DEPTH] = value;
                  held++;
               end else begin
                  head = (head + DEPTH - 1) % DEPTH;
                  held_values[head] = value;
                  held++;
               end
            end
            OP_POP_BACK: begin
               if (held == 0) begin
                  r.status = ST_EMPTY;
                  empty_pops++;
               end else begin
                  r.popped = held_values[(head + held - 1) % DEPTH];
                  held--;
               end
            end
            default: begin
               for (int i = 0; i < held; i++) begin
                  if (held_values[(head + i) % DEPTH] == value) begin
                     r.found = i[FOUND_W-1:0];
                     break;
                  end
               end
               if (r.found == FOUND_NONE) find_misses++;
               else find_hits++;
            end
         endcase
         r.fill = held[FILL_W-1:0];
         if (held > peak_fill) peak_fill = held;
         awaited_results.insert(awaited_results.size(), r);
      endfunction

      // compare one response against the oldest expectation
      function void check_result(logic signed [VAL_W-1:0] popped,
                                 logic signed [FOUND_W-1:0] found,
                                 logic [STATUS_W-1:0] status,
                                 logic [FILL_W-1:0] fill);
         deque_result_type r;
         if (awaited_results.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         r = awaited_results.pop_front();
         if (popped !== r.popped) begin
            $error("popped_value: expected %0d, actual %0d", r.popped, popped);
            errors++;
         end
         if (found !== r.found) begin
            $error("found_position: expected %0d, actual %0d", r.found, found);
            errors++;
         end
         if (status !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, status);
            errors++;
         end
         if (fill !== r.fill) begin
            $error("fill_count: expected %0d, actual %0d", r.fill, fill);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bdq_req_if req_if ();
   bdq_rsp_if rsp_if ();

   bounded_deque_with_search #(.DEPTH(DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   deque_scoreboard sb = new();
   int              sent_count = 0;
   int              idle_cycles = 0;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // offer one operation and hold it until the transfer; valid stays high on return
   task automatic send_op(input op_type op, input logic [VAL_W-1:0] value);
      req_if.valid      <= 1'b1;
      req_if.op         <= op;
      req_if.item_value <= value;
      do @(posedge clock); while (!req_if.ready);
      sb.apply_operation(op, value);
      sent_count++;
   endtask

   // operation mix by phase: 0 fills the deque, 1 drains it, 2 is balanced
   function automatic op_type pick_op(input int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         0: begin
            if (roll < 45) return OP_PUSH_BACK;
            if (roll < 80) return OP_PUSH_FRONT;
            if (roll < 90) return OP_POP_BACK;
            return OP_FIND;
         end
         1: begin
            if (roll < 10) return OP_PUSH_BACK;
            if (roll < 20) return OP_PUSH_FRONT;
            if (roll < 80) return OP_POP_BACK;
            return OP_FIND;
         end
         default: begin
            if (roll < 25) return OP_PUSH_BACK;
            if (roll < 50) return OP_PUSH_FRONT;
            if (roll < 75) return OP_POP_BACK;
            return OP_FIND;
         end
      endcase
   endfunction

   // half the values come from a small pool so that finds hit and duplicates occur
   function automatic logic [VAL_W-1:0] pick_value();
      if ($urandom_range(0, 1) == 0) return $urandom();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'h0000_0001;
         5: return 32'h0000_0002;
         6: return 32'h0000_0003;
         default: return 32'h0000_0005;
      endcase
   endfunction

   // corner cases: empty store, sign extremes, wrap of the front pointer,
   // match at the front and at the back, miss, full store on both ends
   task automatic run_directed();
      send_op(OP_POP_BACK, 32'h0);             // pop on empty
      send_op(OP_FIND, 32'h0);                 // find on empty
      send_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
      send_op(OP_PUSH_FRONT, 32'h8000_0000);   // front pointer wraps below zero
      send_op(OP_PUSH_BACK, 32'h0000_0000);
      send_op(OP_PUSH_BACK, 32'hFFFF_FFFF);
      send_op(OP_FIND, 32'h8000_0000);         // match at the front
      send_op(OP_FIND, 32'hFFFF_FFFF);         // match on the last element
      send_op(OP_FIND, 32'h1234_5678);         // no match
      send_op(OP_POP_BACK, 32'hDEAD_BEEF);     // value ignored on pop
      for (int i = 0; i < 12; i++)
         send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'h0101_0101 * (i + 1));
      send_op(OP_PUSH_BACK, 32'h5A5A_A5A5);    // now full
      send_op(OP_PUSH_BACK, 32'h0000_0001);    // dropped at the back
      send_op(OP_PUSH_FRONT, 32'h0000_0002);   // dropped at the front
      send_op(OP_FIND, 32'h5A5A_A5A5);         // match at the deepest position
      send_op(OP_POP_BACK, 32'h0);
   endtask

   initial begin
      int mode;
      int burst_left;
      mode = 2;
      req_if.valid      <= 1'b0;
      req_if.op         <= OP_PUSH_BACK;
      req_if.item_value <= '0;
      reset             <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      // random part: bursts of back-to-back requests separated by random gaps
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) mode = $urandom_range(0, 2);
         send_op(pick_op(mode), pick_value());
         burst_left--;
         if (burst_left == 0) begin
            req_if.valid      <= 1'b0;
            req_if.item_value <= $urandom();   // noise while idle
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
      req_if.valid <= 1'b0;

      // drain, then let any trailing activity settle
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d operations, peak fill %0d of %0d", sent_count, sb.peak_fill,
               DEPTH);
      $display("find hits %0d, find misses %0d, pushes on full %0d, pops on empty %0d",
               sb.find_hits, sb.find_misses, sb.full_drops, sb.empty_pops);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------------

   // ready follows a stall pattern that is redrawn once its random run length is used up, with one
   // long hold-off in the middle of the run so that requests back up
   initial begin
      int          pattern;
      int          pattern_left;
      logic [7:0]  stall_mask;
      bit          holdoff_done;
      pattern      = 0;
      pattern_left = 0;
      stall_mask   = 8'hFF;
      holdoff_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!holdoff_done && sent_count >= HOLDOFF_AFTER) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLDOFF_LEN) @(posedge clock);
            holdoff_done = 1'b1;
         end else begin
            if (pattern_left == 0) begin
               pattern      = $urandom_range(0, 3);
               pattern_left = $urandom_range(20, 120);
               stall_mask   = 8'($urandom()) | 8'h01;
            end
            case (pattern)
               0: rsp_if.ready <= 1'b1;                              // no stalls
               1: rsp_if.ready <= 1'($urandom_range(0, 1));          // coin flip
               2: begin                                              // rotating mask
                  rsp_if.ready <= stall_mask[0];
                  stall_mask   = {stall_mask[0], stall_mask[7:1]};
               end
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0); // mostly stalled
            endcase
            pattern_left--;
         end
      end
   end

   // check every response transfer
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.popped_value, rsp_if.found_position, rsp_if.status,
                         rsp_if.fill_count);
   end

   // watchdog: give up when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("no transfer for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
